FILE: hw/rtl/isobf_pkg.sv
// ----------------------------------------------------------------------------
// isobf_pkg
// Shared types, protocol codes and the CRC_A byte update for the block framer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package isobf_pkg;

    localparam logic [15:0] CRC_PRESET  = 16'h6363;
    localparam logic [7:0]  PCB_IBLOCK  = 8'h02;
    localparam logic [7:0]  PCB_SWTX    = 8'hF2;
    localparam logic [1:0]  KIND_IBLOCK = 2'd0;
    localparam logic [1:0]  KIND_SWTX   = 2'd1;

    // bytes produced by one input transfer, packed from index 0
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            frame_end;
    } t_group;

    // crc_a (itu-v.41, lsb first) folded over one byte
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] t;
        t = b ^ crc[7:0];
        t = t ^ {t[3:0], 4'b0000};
        return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000}
             ^ {12'h000, t[7:4]};
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/isobf_framer.sv
// ----------------------------------------------------------------------------
// isobf_framer
// Block number and running CRC state; builds the byte group for each transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module isobf_framer (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_first_byte,
    input  wire logic              i_last_byte,
    input  wire logic [1:0]        i_frame_kind,
    output isobf_pkg::t_group      o_group
);
    import isobf_pkg::*;

    logic        r_toggle;
    logic        n_toggle;
    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic        is_i;
    logic        is_s;
    logic        has_pcb;
    logic [7:0]  pcb;
    logic [15:0] crc_base;
    logic [15:0] crc_pcb;
    logic [15:0] crc_data;

    always_comb begin
        is_i     = i_first_byte && (i_frame_kind == KIND_IBLOCK);
        is_s     = i_first_byte && (i_frame_kind == KIND_SWTX);
        has_pcb  = is_i || is_s;
        n_toggle = is_i ? ~r_toggle : r_toggle;
        pcb      = is_i ? (PCB_IBLOCK | {7'b0000000, n_toggle}) : PCB_SWTX;
        crc_base = i_first_byte ? CRC_PRESET : r_crc;
        crc_pcb  = has_pcb ? crc_fold(crc_base, pcb) : crc_base;
        crc_data = crc_fold(crc_pcb, i_data_byte);
        n_crc    = i_last_byte ? CRC_PRESET : crc_data;
    end

    always_comb begin
        o_group.bytes     = '0;
        o_group.frame_end = i_last_byte;
        o_group.last_idx  = {i_last_byte, has_pcb};
        if (has_pcb) begin
            o_group.bytes[0] = pcb;
            o_group.bytes[1] = i_data_byte;
            o_group.bytes[2] = crc_data[7:0];
            o_group.bytes[3] = crc_data[15:8];
        end else begin
            o_group.bytes[0] = i_data_byte;
            o_group.bytes[1] = crc_data[7:0];
            o_group.bytes[2] = crc_data[15:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_toggle <= 1'b1;
            r_crc    <= CRC_PRESET;
        end else if (i_accept) begin
            r_toggle <= n_toggle;
            r_crc    <= n_crc;
        end
    end

    // crc restarts from the preset after every trailer
    a_crc_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last_byte) |=> (r_crc == CRC_PRESET))
        else $error("crc not reloaded after trailer");

    // block number moves only on an accepted i-block start
    a_toggle_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_accept || !is_i) |=> $stable(r_toggle))
        else $error("block number changed without i-block");

endmodule

`default_nettype wire

FILE: hw/rtl/isobf_serializer.sv
// ----------------------------------------------------------------------------
// isobf_serializer
// Result register for one byte group, drained one byte per output transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module isobf_serializer (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire isobf_pkg::t_group i_group,
    output logic                   o_load_ok,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [7:0]             o_out_byte,
    output logic                   o_out_last
);
    import isobf_pkg::*;

    logic       r_valid;
    t_group     r_grp;
    logic [1:0] r_idx;
    logic       at_end;

    assign at_end      = (r_idx == r_grp.last_idx);
    assign o_load_ok   = !r_valid || (i_out_ready && at_end);
    assign o_out_valid = r_valid;
    assign o_out_byte  = r_grp.bytes[r_idx];
    assign o_out_last  = r_grp.frame_end && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (r_valid && i_out_ready) begin
            if (at_end) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_grp <= i_load ? i_group : r_grp;
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_idx <= r_grp.last_idx))
        else $error("byte index past end of group");

    // a group is never dropped before its last byte goes out
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !at_end) |=> (r_valid && !$fell(r_idx == 2'd0) || $past(i_load)
            || r_idx == $past(r_idx) + 2'd1 || r_idx == $past(r_idx)))
        else $error("group dropped early");

    // a new group replaces the old one only once it has fully drained
    a_load_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !(i_out_ready && at_end)) |-> !i_load)
        else $error("group overwritten");

endmodule

`default_nettype wire

FILE: hw/rtl/iso14443_block_framer_crc_a_core.sv
// ----------------------------------------------------------------------------
// iso14443_block_framer_crc_a_core
// ISO 14443-4 block framer: optional PCB, payload bytes, CRC_A trailer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  in      | input     | i_in_valid / o_in_ready   | i_data_byte, i_first_byte,
//          |           |                           | i_last_byte, i_frame_kind
//  out     | output    | o_out_valid / i_out_ready | o_out_byte, o_out_last
//
//  an input transfer yields 1 to 4 output bytes; its group is registered in
//  the serializer at the transfer edge, the first byte can leave in the next
//  cycle, then one byte a cycle while the output is ready
//  the next input transfer can happen in the cycle the last byte of the
//  previous group leaves, so single-byte groups stream at one per cycle
//  while the output is ready; throughput is set by the single output byte lane
//  synchronous active-low reset: block number 1, crc 0x6363, output empty
//  a stall on the output holds the current byte and blocks further input
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iso14443_block_framer_crc_a_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_first_byte,
    input  wire logic       i_last_byte,
    input  wire logic [1:0] i_frame_kind,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_out_last
);
    import isobf_pkg::*;

    t_group group;
    logic   load_ok;
    logic   accept;

    assign o_in_ready = load_ok;
    assign accept     = i_in_valid && load_ok;

    isobf_framer u_framer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .i_last_byte  (i_last_byte),
        .i_frame_kind (i_frame_kind),
        .o_group      (group)
    );

    isobf_serializer u_serializer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_group     (group),
        .o_load_ok   (load_ok),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last)
    );

endmodule

`default_nettype wire

FILE: verif/tb_iso14443_block_framer_crc_a_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_iso14443_block_framer_crc_a_core
// Drives payload bytes into the ISO 14443-4 block framer and checks every
// framed output byte (control byte, payload, CRC_A trailer) in order against
// a bitwise CRC_A predictor. Both sides stall at random, in calm and busy
// stretches. Directed frames come first, then mostly well-formed random frames
// with some stray bytes.
// ----------------------------------------------------------------------------
module tb_iso14443_block_framer_crc_a_core;
    import isobf_pkg::*;

    localparam logic [1:0]  KIND_BARE     = 2'd2;
    localparam logic [1:0]  KIND_SPARE    = 2'd3;
    localparam logic [15:0] CRC_A_REFLECT = 16'h8408;
    localparam int          RANDOM_ITEMS  = 140;
    localparam int          SHOWN_ERRORS  = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
        logic [1:0] kind;
    } t_payload;

    typedef struct packed {
        logic [7:0] value;
        logic       ends;
    } t_framed;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_in_valid   = 1'b0;
    logic [7:0] i_data_byte  = 8'h00;
    logic       i_first_byte = 1'b0;
    logic       i_last_byte  = 1'b0;
    logic [1:0] i_frame_kind = 2'd0;
    logic       i_out_ready  = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_out_last;

    t_payload   payload_queue[$];
    t_framed    framed_due[$];
    t_payload   next_payload;
    t_framed    due_byte;

    logic       block_num = 1'b1;
    logic [15:0] crc_run  = CRC_PRESET;
    int         mismatches = 0;
    logic       in_taken  = 1'b0;
    logic       out_taken = 1'b0;
    int         send_wait = 0;
    int         take_wait = 0;
    bit         in_calm   = 1'b0;
    int         in_left   = 0;
    bit         out_calm  = 1'b0;
    int         out_left  = 0;

    iso14443_block_framer_crc_a_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .i_last_byte  (i_last_byte),
        .i_frame_kind (i_frame_kind),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_out_last   (o_out_last)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // reflected crc_a, one bit at a time
    function automatic logic [15:0] crc_a_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_A_REFLECT) : (c >> 1);
        end
        return c;
    endfunction

    function automatic int next_gap(inout bit calm, inout int left);
        if (left == 0) begin
            calm = ($urandom_range(0, 2) == 0);
            left = $urandom_range(10, 40);
        end
        left--;
        if (calm) begin
            return 0;
        end
        return ($urandom_range(0, 1) == 1) ? $urandom_range(0, 3) : $urandom_range(0, 17);
    endfunction

    task automatic emit_byte(input logic [7:0] b, input logic ends);
        framed_due.push_back('{value: b, ends: ends});
    endtask

    task automatic frame_payload(input t_payload p);
        logic [7:0] pcb;
        if (p.first) begin
            crc_run = CRC_PRESET;
            if (p.kind == KIND_IBLOCK) begin
                block_num = ~block_num;
                pcb = PCB_IBLOCK | {7'd0, block_num};
                crc_run = crc_a_byte(crc_run, pcb);
                emit_byte(pcb, 1'b0);
            end else if (p.kind == KIND_SWTX) begin
                crc_run = crc_a_byte(crc_run, PCB_SWTX);
                emit_byte(PCB_SWTX, 1'b0);
            end
        end
        crc_run = crc_a_byte(crc_run, p.data);
        emit_byte(p.data, 1'b0);
        if (p.last) begin
            emit_byte(crc_run[7:0], 1'b0);
            emit_byte(crc_run[15:8], 1'b1);
            crc_run = CRC_PRESET;
        end
    endtask

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= SHOWN_ERRORS) begin
            $display("%0t mismatch: %s", $realtime, what);
        end
    endtask

    task automatic add_payload(input logic [7:0] data, input logic first, input logic last,
                               input logic [1:0] kind);
        payload_queue.push_back('{data: data, first: first, last: last, kind: kind});
    endtask

    // transfer bookkeeping, output check and prediction
    always @(posedge i_clk) begin
        in_taken  <= i_rst_n && i_in_valid && o_in_ready;
        out_taken <= i_rst_n && o_out_valid && i_out_ready;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (framed_due.size() == 0) begin
                note_mismatch($sformatf("unexpected byte %02h last %0b", o_out_byte, o_out_last));
            end else begin
                due_byte = framed_due.pop_front();
                if (o_out_byte !== due_byte.value || o_out_last !== due_byte.ends) begin
                    note_mismatch($sformatf("expected byte %02h last %0b, got byte %02h last %0b",
                                            due_byte.value, due_byte.ends, o_out_byte, o_out_last));
                end
            end
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            frame_payload('{data: i_data_byte, first: i_first_byte, last: i_last_byte,
                            kind: i_frame_kind});
        end
    end

    // input driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (in_taken) begin
                send_wait = next_gap(in_calm, in_left);
            end
            if (send_wait > 0 || payload_queue.size() == 0) begin
                i_in_valid <= 1'b0;
                if (send_wait > 0) begin
                    send_wait--;
                end
            end else begin
                next_payload = payload_queue.pop_front();
                i_in_valid   <= 1'b1;
                i_data_byte  <= next_payload.data;
                i_first_byte <= next_payload.first;
                i_last_byte  <= next_payload.last;
                i_frame_kind <= next_payload.kind;
            end
        end
    end

    // output ready driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (out_taken) begin
                take_wait = next_gap(out_calm, out_left);
            end
            if (take_wait > 0) begin
                i_out_ready <= 1'b0;
                take_wait--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        int         frame_len;
        int         pick;
        int         target;
        logic [1:0] kind_pick;

        // one-byte i-blocks, block number toggles
        add_payload(8'h00, 1'b1, 1'b1, KIND_IBLOCK);
        add_payload(8'hFF, 1'b1, 1'b1, KIND_IBLOCK);
        // wtx reply
        add_payload(8'h01, 1'b1, 1'b1, KIND_SWTX);
        // bare frame, three bytes
        add_payload(8'hA5, 1'b1, 1'b0, KIND_BARE);
        add_payload(8'h5A, 1'b0, 1'b0, KIND_IBLOCK);
        add_payload(8'h80, 1'b0, 1'b1, KIND_SWTX);
        // unused kind acts as bare
        add_payload(8'h7F, 1'b1, 1'b1, KIND_SPARE);
        // i-block with kind noise on later bytes
        add_payload(8'h12, 1'b1, 1'b0, KIND_IBLOCK);
        add_payload(8'h34, 1'b0, 1'b0, KIND_SPARE);
        add_payload(8'hFE, 1'b0, 1'b1, KIND_SWTX);
        // bytes with no frame start
        add_payload(8'h33, 1'b0, 1'b0, KIND_SPARE);
        add_payload(8'hCC, 1'b0, 1'b1, KIND_IBLOCK);
        // frame restarted before its end
        add_payload(8'h55, 1'b1, 1'b0, KIND_SWTX);
        add_payload(8'hAA, 1'b1, 1'b1, KIND_IBLOCK);
        // trailer without a start, then another i-block
        add_payload(8'h0F, 1'b0, 1'b1, KIND_BARE);
        add_payload(8'hF0, 1'b1, 1'b0, KIND_IBLOCK);
        add_payload(8'h00, 1'b0, 1'b0, KIND_BARE);
        add_payload(8'hFF, 1'b0, 1'b1, KIND_BARE);

        target = payload_queue.size() + RANDOM_ITEMS;
        while (payload_queue.size() < target) begin
            if ($urandom_range(0, 9) == 0) begin
                add_payload(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
            end else begin
                frame_len = ($urandom_range(0, 2) == 0) ? $urandom_range(4, 9)
                                                        : $urandom_range(1, 3);
                pick = $urandom_range(0, 19);
                if (pick < 8) begin
                    kind_pick = KIND_IBLOCK;
                end else if (pick < 13) begin
                    kind_pick = KIND_SWTX;
                end else if (pick < 18) begin
                    kind_pick = KIND_BARE;
                end else begin
                    kind_pick = KIND_SPARE;
                end
                for (int k = 0; k < frame_len; k++) begin
                    add_payload(8'($urandom_range(0, 255)), k == 0, k == frame_len - 1,
                                (k == 0) ? kind_pick : 2'($urandom_range(0, 3)));
                end
            end
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (payload_queue.size() != 0 || i_in_valid || framed_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (32) @(posedge i_clk);

        if (mismatches == 0 && framed_due.size() == 0) begin
            $display("PASS iso14443_block_framer_crc_a_core");
        end else begin
            $display("FAIL iso14443_block_framer_crc_a_core");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL iso14443_block_framer_crc_a_core");
        $finish;
    end

endmodule

FILE: iso14443_block_framer_crc_a_core.f
hw/rtl/isobf_pkg.sv
hw/rtl/isobf_framer.sv
hw/rtl/isobf_serializer.sv
hw/rtl/iso14443_block_framer_crc_a_core.sv
verif/tb_iso14443_block_framer_crc_a_core.sv
